// ===== rtl/egs_pkg.sv =====
// egs_pkg: shared width, types, controller/datapath command and status, modular helpers
// no dependencies; compiled first
`default_nettype none

package egs_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned ADDR_W = 4;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_GENERATOR   = 2'd1;
  localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;

  // serial jobs run on the shared shift-add datapath
  typedef enum logic [3:0] {
    JB_REDG,   // generator mod q
    JB_SQ,     // pacc * pacc mod q
    JB_MULB,   // pacc * base mod q
    JB_REDK,   // nonce mod n
    JB_DIV,    // one euclid round: ea / eb with quotient folded into t update
    JB_REDX,   // private key mod n
    JB_MULXR,  // (x mod n) * r mod n
    JB_REDM,   // hash mod n, then difference
    JB_MULS    // kinv * diff mod n
  } job_e;

  typedef struct packed {
    logic init;
    logic ld;
    logic step_a;
    logic step_b;
    logic st;
    job_e job;
    logic pw_start;
    logic pw_k;
    logic pw_save;
    logic exp_shift;
    logic inv_set;
    logic out_load;
  } egs_cmd_t;

  typedef struct packed {
    logic q_small;
    logic exp_msb;
    logic eb_zero;
    logic ea_one;
  } egs_sts_t;

  // (a + b) mod m with a, b < m
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    word_t gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  // (a - b) mod m with a, b < m
  function automatic word_t sub_mod(word_t a, word_t b, word_t m);
    return (a >= b) ? (a - b) : (m - (b - a));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/egs_in_if.sv =====
// egs_in_if: input channel, one beat carries a message hash and a nonce
// depends on egs_pkg
`default_nettype none

interface egs_in_if;
  import egs_pkg::*;
  logic  valid;
  logic  ready;
  word_t msg_hash;
  word_t nonce;
  modport source (output valid, msg_hash, nonce, input ready);
  modport sink   (input valid, msg_hash, nonce, output ready);
endinterface

`default_nettype wire

// ===== rtl/egs_out_if.sv =====
// egs_out_if: result channel, one beat carries the signature and public key
// depends on egs_pkg
`default_nettype none

interface egs_out_if;
  import egs_pkg::*;
  logic  valid;
  logic  ready;
  word_t sig_r;
  word_t sig_s;
  word_t public_key;
  logic  nonce_invalid;
  modport source (output valid, sig_r, sig_s, public_key, nonce_invalid, input ready);
  modport sink   (input valid, sig_r, sig_s, public_key, nonce_invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/egs_dpath.sv =====
// egs_dpath: operand registers, shared serial mod-multiply / restoring-divide unit
// depends on egs_pkg; driven by egs_ctrl through egs_cmd_t
`default_nettype none

module egs_dpath (
  input  logic             clk_i,
  input  egs_pkg::word_t   modulus_i,
  input  egs_pkg::word_t   generator_i,
  input  egs_pkg::word_t   private_key_i,
  input  egs_pkg::word_t   msg_hash_i,
  input  egs_pkg::word_t   nonce_i,
  input  egs_pkg::egs_cmd_t cmd_i,
  output egs_pkg::egs_sts_t sts_o,
  output egs_pkg::word_t   sig_r_o,
  output egs_pkg::word_t   sig_s_o,
  output egs_pkg::word_t   public_key_o,
  output logic             nonce_invalid_o
);
  import egs_pkg::*;

  word_t n_q, m_q, k_q;
  word_t res_q, shf_q, opa_q, prod_q;
  logic  qb_q;
  word_t pacc_q, exp_q, gb_q;
  word_t ea_q, eb_q, t0_q, t1_q, xrr_q;
  word_t r_q, s_q, pub_q;
  logic  inv_q;
  word_t out_r_q, out_s_q, out_pub_q;
  logic  out_inv_q;

  word_t            md;
  logic             div_mode;
  logic [WIDTH:0]   rem2;
  logic [WIDTH:0]   rem_sub;
  logic             rem_ge;

  always_comb begin
    case (cmd_i.job)
      JB_REDG, JB_SQ, JB_MULB: md = modulus_i;
      JB_DIV:                  md = eb_q;
      default:                 md = n_q;
    endcase
    div_mode = cmd_i.job inside {JB_REDG, JB_REDK, JB_DIV, JB_REDX, JB_REDM};
    rem2     = {res_q, shf_q[WIDTH-1]};
    rem_ge   = rem2 >= {1'b0, md};
    rem_sub  = rem2 - {1'b0, md};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      m_q   <= msg_hash_i;
      k_q   <= nonce_i;
      n_q   <= modulus_i - WIDTH'(1);
      r_q   <= '0;
      s_q   <= '0;
      pub_q <= '0;
      inv_q <= 1'b0;
    end
    if (cmd_i.inv_set) begin
      inv_q <= 1'b1;
    end

    // exponentiation bookkeeping
    if (cmd_i.pw_start) begin
      pacc_q <= WIDTH'(1);
      exp_q  <= cmd_i.pw_k ? k_q : private_key_i;
    end
    if (cmd_i.exp_shift) begin
      exp_q <= exp_q << 1;
    end
    if (cmd_i.pw_save) begin
      if (cmd_i.pw_k) begin
        r_q <= pacc_q;
      end else begin
        pub_q <= pacc_q;
      end
    end

    // operand load
    if (cmd_i.ld) begin
      res_q  <= '0;
      prod_q <= '0;
      case (cmd_i.job)
        JB_REDG:  shf_q <= generator_i;
        JB_SQ: begin
          opa_q <= pacc_q;
          shf_q <= pacc_q;
        end
        JB_MULB: begin
          opa_q <= gb_q;
          shf_q <= pacc_q;
        end
        JB_REDK:  shf_q <= k_q;
        JB_DIV:   shf_q <= ea_q;
        JB_REDX:  shf_q <= private_key_i;
        JB_MULXR: begin
          opa_q <= res_q;
          shf_q <= r_q;
        end
        JB_REDM:  shf_q <= m_q;
        JB_MULS: begin
          opa_q <= xrr_q;
          shf_q <= t0_q;
        end
        default: ;
      endcase
    end

    // first half of a bit: double or shift-subtract
    if (cmd_i.step_a) begin
      if (div_mode) begin
        res_q  <= rem_ge ? rem_sub[WIDTH-1:0] : rem2[WIDTH-1:0];
        qb_q   <= rem_ge;
        prod_q <= add_mod(prod_q, prod_q, n_q);
      end else begin
        res_q <= add_mod(res_q, res_q, md);
      end
    end

    // second half: conditional add, advance the scanned operand
    if (cmd_i.step_b) begin
      if (div_mode) begin
        if (qb_q) begin
          prod_q <= add_mod(prod_q, t1_q, n_q);
        end
      end else if (shf_q[WIDTH-1]) begin
        res_q <= add_mod(res_q, opa_q, md);
      end
      shf_q <= shf_q << 1;
    end

    // result write-back
    if (cmd_i.st) begin
      case (cmd_i.job)
        JB_REDG:         gb_q <= res_q;
        JB_SQ, JB_MULB:  pacc_q <= res_q;
        JB_REDK: begin
          ea_q <= n_q;
          eb_q <= res_q;
          t0_q <= '0;
          t1_q <= WIDTH'(1);
        end
        JB_DIV: begin
          ea_q <= eb_q;
          eb_q <= res_q;
          t0_q <= t1_q;
          t1_q <= sub_mod(t0_q, prod_q, n_q);
        end
        JB_MULXR:        xrr_q <= res_q;
        JB_REDM:         xrr_q <= sub_mod(res_q, xrr_q, n_q);
        JB_MULS:         s_q <= res_q;
        default: ;
      endcase
    end

    if (cmd_i.out_load) begin
      out_r_q   <= r_q;
      out_s_q   <= s_q;
      out_pub_q <= pub_q;
      out_inv_q <= inv_q;
    end
  end

  assign sts_o.q_small = modulus_i < WIDTH'(3);
  assign sts_o.exp_msb = exp_q[WIDTH-1];
  assign sts_o.eb_zero = (eb_q == '0);
  assign sts_o.ea_one  = (ea_q == WIDTH'(1));

  assign sig_r_o         = out_r_q;
  assign sig_s_o         = out_s_q;
  assign public_key_o    = out_pub_q;
  assign nonce_invalid_o = out_inv_q;

endmodule

`default_nettype wire

// ===== rtl/egs_ctrl.sv =====
// egs_ctrl: sequencer for exponentiations, euclid rounds and the final products
// depends on egs_pkg; commands egs_dpath
`default_nettype none

module egs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  egs_pkg::egs_sts_t sts_i,
  output egs_pkg::egs_cmd_t cmd_o
);
  import egs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LD, S_A, S_B, S_ST, S_PSTART, S_PNEXT, S_ECHK, S_OUT
  } state_e;

  localparam cnt_t LAST = cnt_t'(WIDTH - 1);

  state_e state_q;
  job_e   job_q;
  cnt_t   cnt_q, ecnt_q;
  logic   pw_k_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.job  = job_q;
    cmd_o.pw_k = pw_k_q;
    case (state_q)
      S_IDLE:   cmd_o.init = in_valid_i;
      S_CHK:    cmd_o.inv_set = sts_i.q_small;
      S_LD:     cmd_o.ld = 1'b1;
      S_A:      cmd_o.step_a = 1'b1;
      S_B:      cmd_o.step_b = 1'b1;
      S_ST:     cmd_o.st = 1'b1;
      S_PSTART: cmd_o.pw_start = 1'b1;
      S_PNEXT: begin
        cmd_o.exp_shift = 1'b1;
        cmd_o.pw_save   = (ecnt_q == LAST);
      end
      S_ECHK:   cmd_o.inv_set = sts_i.eb_zero && !sts_i.ea_one;
      S_OUT:    cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= JB_REDG;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      pw_k_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (sts_i.q_small) begin
            state_q <= S_OUT;
          end else begin
            job_q   <= JB_REDG;
            state_q <= S_LD;
          end
        end
        S_LD: begin
          cnt_q   <= '0;
          state_q <= S_A;
        end
        S_A: state_q <= S_B;
        S_B: begin
          if (cnt_q == LAST) begin
            state_q <= S_ST;
          end else begin
            cnt_q   <= cnt_q + cnt_t'(1);
            state_q <= S_A;
          end
        end
        S_ST: begin
          case (job_q)
            JB_REDG: begin
              pw_k_q  <= 1'b0;
              state_q <= S_PSTART;
            end
            JB_SQ: begin
              if (sts_i.exp_msb) begin
                job_q   <= JB_MULB;
                state_q <= S_LD;
              end else begin
                state_q <= S_PNEXT;
              end
            end
            JB_MULB:         state_q <= S_PNEXT;
            JB_REDK, JB_DIV: state_q <= S_ECHK;
            JB_REDX: begin
              job_q   <= JB_MULXR;
              state_q <= S_LD;
            end
            JB_MULXR: begin
              job_q   <= JB_REDM;
              state_q <= S_LD;
            end
            JB_REDM: begin
              job_q   <= JB_MULS;
              state_q <= S_LD;
            end
            JB_MULS:         state_q <= S_OUT;
            default:         state_q <= S_IDLE;
          endcase
        end
        S_PSTART: begin
          ecnt_q  <= '0;
          job_q   <= JB_SQ;
          state_q <= S_LD;
        end
        S_PNEXT: begin
          if (ecnt_q == LAST) begin
            job_q   <= pw_k_q ? JB_REDX : JB_REDK;
            state_q <= S_LD;
          end else begin
            ecnt_q  <= ecnt_q + cnt_t'(1);
            job_q   <= JB_SQ;
            state_q <= S_LD;
          end
        end
        S_ECHK: begin
          if (sts_i.eb_zero) begin
            if (sts_i.ea_one) begin
              pw_k_q  <= 1'b1;
              state_q <= S_PSTART;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            job_q   <= JB_DIV;
            state_q <= S_LD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/elgamal_signature_generator.sv =====
// elgamal signature generator: top level with apb register file, controller and datapath
// depends on egs_pkg, egs_in_if, egs_out_if, egs_ctrl, egs_dpath
//
// one input beat (message hash m, nonce k) yields one result beat: public key
// alpha^x mod q, r = alpha^k mod q and s = k^-1 * (m - x*r) mod (q-1), with the
// difference reduced into 0..q-2. a nonce with no inverse mod q-1 raises
// nonce_invalid and zeroes r and s; a modulus below three gives all zeros and
// nonce_invalid set. one item is in flight at a time. every product, reduction
// and euclid round runs as a job on one shared shift-add unit, which handles each
// operand bit in a double or shift-subtract step and a conditional-add step;
// each exponentiation is 32 squarings plus one multiply per set exponent bit,
// and euclid takes one job per quotient round (at most about 47). an invalid
// nonce skips the second exponentiation and the final products, and a modulus
// below three skips every job. the next item is taken while a finished result
// still waits in the output register.
// registers (write only while idle): modulus at 0x0, generator at 0x4,
// private key at 0x8; other addresses are ignored
`default_nettype none

module elgamal_signature_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  egs_in_if.sink                     in_i,
  egs_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [egs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import egs_pkg::*;

  word_t    modulus_q, generator_q, private_key_q;
  logic     wr_en;
  logic [1:0] reg_idx;
  egs_cmd_t cmd;
  egs_sts_t sts;

  // apb register file, zero wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= WIDTH'(3);
      generator_q   <= WIDTH'(2);
      private_key_q <= WIDTH'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODULUS:     modulus_q     <= pwdata;
        REG_GENERATOR:   generator_q   <= pwdata;
        REG_PRIVATE_KEY: private_key_q <= pwdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS:     prdata = modulus_q;
      REG_GENERATOR:   prdata = generator_q;
      REG_PRIVATE_KEY: prdata = private_key_q;
      default:         prdata = '0;
    endcase
  end

  // sequencer: owns the handshakes and the job order
  egs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: operands, shared serial unit, output register
  egs_dpath u_dpath (
    .clk_i          (clk_i),
    .modulus_i      (modulus_q),
    .generator_i    (generator_q),
    .private_key_i  (private_key_q),
    .msg_hash_i     (in_i.msg_hash),
    .nonce_i        (in_i.nonce),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sig_r_o        (out_o.sig_r),
    .sig_s_o        (out_o.sig_s),
    .public_key_o   (out_o.public_key),
    .nonce_invalid_o(out_o.nonce_invalid)
  );

endmodule

`default_nettype wire

// ===== rtl/egs_checker.sv =====
// egs_checker: port-level assertions on the signature generator, bound to the top level
// depends on egs_pkg and elgamal_signature_generator
`default_nettype none

module egs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input egs_pkg::word_t sig_r_i,
  input egs_pkg::word_t sig_s_i,
  input egs_pkg::word_t public_key_i,
  input logic           nonce_invalid_i
);
  import egs_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // one item in flight: no new input right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a result never appears on the cycle right after an input beat
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_beat))
    else $error("result shown too soon after input beat");

  // an invalid nonce carries zero signature parts
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && nonce_invalid_i) |-> (sig_r_i == '0 && sig_s_i == '0))
    else $error("invalid nonce with nonzero signature");

  // stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(sig_r_i) && $stable(sig_s_i) &&
       $stable(public_key_i) && $stable(nonce_invalid_i)))
    else $error("stalled result beat changed");

endmodule

bind elgamal_signature_generator egs_checker u_egs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sig_r_i        (out_o.sig_r),
  .sig_s_i        (out_o.sig_s),
  .public_key_i   (out_o.public_key),
  .nonce_invalid_i(out_o.nonce_invalid)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for the elgamal signature generator: apb register writes, random signing beats
// depends on egs_pkg, egs_in_if, egs_out_if and the elgamal_signature_generator rtl
`timescale 1ns / 1ps

// signature results that are still owed by the block, in order
class sig_scoreboard;
  egs_pkg::word_t exp_r[$];
  egs_pkg::word_t exp_s[$];
  egs_pkg::word_t exp_pub[$];
  logic           exp_inv[$];
  int unsigned    n_checked;

  function void note_signature(egs_pkg::word_t r, egs_pkg::word_t s,
                               egs_pkg::word_t pub, logic inv);
    exp_r.push_back(r);
    exp_s.push_back(s);
    exp_pub.push_back(pub);
    exp_inv.push_back(inv);
  endfunction

  function int pending();
    return exp_r.size();
  endfunction

  // returns a bit mask of mismatching fields, bit 4 when nothing was owed
  function int check_signature(egs_pkg::word_t r, egs_pkg::word_t s,
                               egs_pkg::word_t pub, logic inv);
    int bad;
    bad = 0;
    if (exp_r.size() == 0) begin
      return 16;
    end
    if (r !== exp_r[0]) bad |= 1;
    if (s !== exp_s[0]) bad |= 2;
    if (pub !== exp_pub[0]) bad |= 4;
    if (inv !== exp_inv[0]) bad |= 8;
    void'(exp_r.pop_front());
    void'(exp_s.pop_front());
    void'(exp_pub.pop_front());
    void'(exp_inv.pop_front());
    n_checked++;
    return bad;
  endfunction
endclass

module testbench;
  import egs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  egs_in_if  in_ch();
  egs_out_if out_ch();

  elgamal_signature_generator u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sig_scoreboard sb;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_invalid;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          hold_cycles;

  // our copy of the configuration
  word_t cfg_q, cfg_g, cfg_x;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous limit: 143 items plus stalls
  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------
  // predictor, built on plain 64-bit arithmetic
  // ---------------------------------------------------------------
  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    // operands below 2^32 so the product fits in 64 bits
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned powmod(longint unsigned base, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // inverse of k mod n via extended euclid on signed 64-bit values
  function automatic bit invmod(longint unsigned k, longint unsigned n,
                                output longint unsigned inv);
    longint a, b, t0, t1, qq, tmp;
    a = n; b = k % n; t0 = 0; t1 = 1;
    inv = 0;
    while (b != 0) begin
      qq = a / b;
      tmp = a - qq * b; a = b; b = tmp;
      tmp = t0 - qq * t1; t0 = t1; t1 = tmp;
    end
    if (a != 1) return 1'b0;
    t0 = t0 % longint'(n);
    if (t0 < 0) t0 += n;
    inv = t0;
    return 1'b1;
  endfunction

  task automatic predict_signature(word_t m, word_t k);
    longint unsigned q, n, r, s, pub, kinv, xr, mm, diff;
    q = cfg_q;
    if (q < 3) begin
      sb.note_signature('0, '0, '0, 1'b1);
      n_invalid++;
      return;
    end
    n = q - 1;
    pub = powmod(cfg_g, cfg_x, q);
    if (!invmod(k, n, kinv)) begin
      sb.note_signature('0, '0, word_t'(pub), 1'b1);
      n_invalid++;
      return;
    end
    r = powmod(cfg_g, k, q);
    xr = mulmod(cfg_x, r, n);
    mm = m % n;
    // difference kept in 0..n-1, never negative
    diff = (mm >= xr) ? mm - xr : n - (xr - mm);
    s = mulmod(kinv, diff, n);
    sb.note_signature(word_t'(r), word_t'(s), word_t'(pub), 1'b0);
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------
  // apb register write: setup then access, pready always high
  // ---------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODULUS:     cfg_q = value;
      REG_GENERATOR:   cfg_g = value;
      REG_PRIVATE_KEY: cfg_x = value;
      default: ;
    endcase
  endtask

  // write to an unused address: must be ignored
  task automatic write_unused(word_t value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({2'd3, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // ---------------------------------------------------------------
  // input beat driver, random gaps before each beat
  // valid stays up after a beat until the next gap or the drain
  // ---------------------------------------------------------------
  task automatic send_beat(word_t m, word_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.msg_hash <= m;
    in_ch.nonce    <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_signature(m, k);
    n_sent++;
  endtask

  // pause until every owed result is back, plus drain slack
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // a random nonce; mostly odd so that many have an inverse
  function automatic word_t rand_nonce();
    word_t k;
    k = $urandom();
    if ($urandom_range(3) != 0) k[0] = 1'b1;
    if (k == 0) k = 1;
    return k;
  endfunction

  // known 32-bit primes and small ones with primitive roots
  word_t primes[6] = '{32'hFFFF_FFFB, 32'd4294967291, 32'd2147483647, 32'd65521,
                       32'd1000003, 32'd23};
  word_t roots[6]  = '{32'd2, 32'd2, 32'd7, 32'd17, 32'd2, 32'd5};

  // ---------------------------------------------------------------
  // result side: ready with random stalls and an optional long hold-off
  // ---------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    int bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bad = sb.check_signature(out_ch.sig_r, out_ch.sig_s, out_ch.public_key,
                               out_ch.nonce_invalid);
      if (bad == 16) report_mismatch("result with nothing expected");
      else if (bad != 0)
        report_mismatch($sformatf("fields %b wrong: r=%h s=%h pub=%h inv=%b",
                        bad[3:0], out_ch.sig_r, out_ch.sig_s, out_ch.public_key,
                        out_ch.nonce_invalid));
    end
  end

  // long receiver hold-off counted in its own process
  initial begin
    hold_off = 1'b0;
    wait (hold_cycles > 0);
    hold_off = 1'b1;
    repeat (hold_cycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    int p;
    int guard;
    sb = new();
    n_errors = 0; n_sent = 0; n_invalid = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    cfg_q = 3; cfg_g = 2; cfg_x = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.msg_hash = '0; in_ch.nonce = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: q = 3, n = 2
    send_beat(32'd0, 32'd1);
    send_beat(32'hFFFF_FFFF, 32'd2);
    wait_drained();

    // modulus below three, both small values
    write_reg(REG_MODULUS, 32'd2);
    write_unused(32'd1234);
    send_beat(32'd5, 32'd3);
    wait_drained();
    write_reg(REG_MODULUS, 32'd0);
    send_beat(32'd5, 32'd3);
    wait_drained();

    // largest 32-bit prime with field extremes
    write_reg(REG_MODULUS, 32'hFFFF_FFFB);
    write_reg(REG_GENERATOR, 32'd2);
    write_reg(REG_PRIVATE_KEY, 32'hFFFF_FFF9);
    send_beat(32'd0, 32'd1);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFA, 32'hFFFF_FFFA);   // nonce equal to q-1
    send_beat(32'h1234_5678, 32'd2);           // even nonce, no inverse
    send_beat(32'hFFFF_FFFB, 32'd7);           // hash not below modulus
    wait_drained();

    // out-of-range key and generator
    write_reg(REG_PRIVATE_KEY, 32'd0);
    write_reg(REG_GENERATOR, 32'hFFFF_FFFB);   // multiple of q
    send_beat(32'd99, 32'd3);
    wait_drained();
    write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
    write_reg(REG_PRIVATE_KEY, 32'hFFFF_FFFF);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      p = ph;
      write_reg(REG_MODULUS, primes[p]);
      write_reg(REG_GENERATOR, roots[p]);
      write_reg(REG_PRIVATE_KEY, ($urandom() % (primes[p] - 2)) + 1);
      if (ph == 4) hold_cycles = 40000;   // block fills up and stalls its input
      for (int i = 0; i < 22; i++) begin
        word_t m;
        m = ($urandom_range(7) == 0) ? $urandom() : $urandom() % primes[p];
        send_beat(m, rand_nonce());
      end
      wait_drained();
    end

    send_idle_pct = 0;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    $display("run covered %0d signing beats, %0d with invalid nonce or small modulus",
             n_sent, n_invalid);
    $display("checked %0d results over a dozen register settings", sb.n_checked);
    if (n_errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
